// ----- rtl/core/gfmac_pkg.sv -----
// Shared types, constants and GF(2^8) arithmetic functions for the multiply-accumulate unit.
`default_nettype none

package gfmac_pkg;

    localparam int OP_W       = 3;
    localparam int BYTE_W     = 8;
    localparam int WORD_BYTES = 8;
    localparam int WORD_W     = WORD_BYTES * BYTE_W;
    localparam int COUNT_W    = 4;

    // Number of lanes the region operations may touch; the word holds eight.
    localparam int LANES      = 8;
    localparam int LANE_LIMIT = (LANES < WORD_BYTES) ? LANES : WORD_BYTES;

    localparam logic [OP_W-1:0] OP_MUL        = 3'd0;
    localparam logic [OP_W-1:0] OP_DIV        = 3'd1;
    localparam logic [OP_W-1:0] OP_INV        = 3'd2;
    localparam logic [OP_W-1:0] OP_REGION_MUL = 3'd3;
    localparam logic [OP_W-1:0] OP_REGION_XOR = 3'd4;

    // Low byte of the field polynomial x^8+x^4+x^3+x^2+1.
    localparam logic [BYTE_W-1:0] GF_POLY_LOW = 8'h1d;

    typedef logic [255:0][BYTE_W-1:0] gf_table_t;

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [WORD_W-1:0]  data_bytes;
        logic [BYTE_W-1:0]  multiplier;
        logic [WORD_W-1:0]  accumulator_bytes;
        logic [COUNT_W-1:0] byte_count;
    } item_t;

    // Shift-and-add product, reducing by the polynomial after each shift.
    function automatic logic [BYTE_W-1:0] gf_mul(input logic [BYTE_W-1:0] x,
                                                  input logic [BYTE_W-1:0] y);
        logic [BYTE_W-1:0] a;
        logic [BYTE_W-1:0] acc;
        a   = x;
        acc = '0;
        for (int k = 0; k < BYTE_W; k++)
        begin
            if (y[k])
            begin
                acc = acc ^ a;
            end
            a = {a[BYTE_W-2:0], 1'b0} ^ (a[BYTE_W-1] ? GF_POLY_LOW : '0);
        end
        return acc;
    endfunction

    // Inverse as x^254 by square-and-multiply; evaluated only at elaboration.
    function automatic gf_table_t build_inv_table();
        gf_table_t         tbl;
        logic [BYTE_W-1:0] r;
        logic [BYTE_W-1:0] b;
        logic [BYTE_W-1:0] e;
        for (int i = 0; i < 256; i++)
        begin
            r = 8'd1;
            b = BYTE_W'(i);
            e = 8'd254;
            for (int k = 0; k < BYTE_W; k++)
            begin
                if (e[k])
                begin
                    r = gf_mul(r, b);
                end
                b = gf_mul(b, b);
            end
            tbl[i] = r;
        end
        return tbl;
    endfunction

    localparam gf_table_t GF_INV_TABLE = build_inv_table();

endpackage

`default_nettype wire

// ----- rtl/core/gfmac_in_if.sv -----
// Request channel: valid/ready handshake carrying one operation beat.
`default_nettype none

interface gfmac_in_if
    import gfmac_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     operation;
    logic [WORD_W-1:0]   data_bytes;
    logic [BYTE_W-1:0]   multiplier;
    logic [WORD_W-1:0]   accumulator_bytes;
    logic [COUNT_W-1:0]  byte_count;

    modport source (
        output valid, operation, data_bytes, multiplier, accumulator_bytes, byte_count,
        input  ready
    );

    modport sink (
        input  valid, operation, data_bytes, multiplier, accumulator_bytes, byte_count,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/core/gfmac_out_if.sv -----
// Response channel: valid/ready handshake carrying one result beat.
`default_nettype none

interface gfmac_out_if
    import gfmac_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] result_bytes;

    modport source (
        output valid, result_bytes,
        input  ready
    );

    modport sink (
        input  valid, result_bytes,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/core/gfmac_lane.sv -----
// One byte lane of the region datapath: constant multiply, optional XOR, pass-through.
`default_nettype none

module gfmac_lane
    import gfmac_pkg::*;
(
    input  wire logic [BYTE_W-1:0] src,
    input  wire logic [BYTE_W-1:0] multiplier,
    input  wire logic [BYTE_W-1:0] acc,
    input  wire logic              enable,
    input  wire logic              do_xor,
    output      logic [BYTE_W-1:0] result
);

    logic [BYTE_W-1:0] product;

    assign product = gf_mul(src, multiplier);

    always_comb
    begin
        if (!enable)
        begin
            result = acc;
        end
        else if (do_xor)
        begin
            result = product ^ acc;
        end
        else
        begin
            result = product;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/gfmac_datapath.sv -----
// Combinational datapath between the input register and the result register.
`default_nettype none

module gfmac_datapath
    import gfmac_pkg::*;
(
    input  wire item_t             item,
    output      logic [WORD_W-1:0] result_bytes
);

    logic [BYTE_W-1:0] src_low;
    logic [BYTE_W-1:0] scalar_operand;
    logic [BYTE_W-1:0] scalar_product;
    logic [BYTE_W-1:0] scalar_inverse;
    logic [WORD_W-1:0] region_result;
    logic              region_xor;

    assign src_low = item.data_bytes[BYTE_W-1:0];

    // Division shares the scalar multiplier: multiply by the table inverse of the divisor.
    assign scalar_operand = (item.operation == OP_DIV) ? GF_INV_TABLE[item.multiplier]
                                                       : item.multiplier;
    assign scalar_product = gf_mul(src_low, scalar_operand);
    assign scalar_inverse = GF_INV_TABLE[src_low];

    assign region_xor = (item.operation == OP_REGION_XOR);

    for (genvar k = 0; k < WORD_BYTES; k++)
    begin : g_lane
        logic lane_enable;

        assign lane_enable = (COUNT_W'(k) < item.byte_count) && (k < LANE_LIMIT);

        gfmac_lane u_lane (
            .src        (item.data_bytes[k*BYTE_W +: BYTE_W]),
            .multiplier (item.multiplier),
            .acc        (item.accumulator_bytes[k*BYTE_W +: BYTE_W]),
            .enable     (lane_enable),
            .do_xor     (region_xor),
            .result     (region_result[k*BYTE_W +: BYTE_W])
        );
    end

    always_comb
    begin
        case (item.operation)
            OP_MUL, OP_DIV:
            begin
                result_bytes = {{(WORD_W-BYTE_W){1'b0}}, scalar_product};
            end
            OP_INV:
            begin
                result_bytes = {{(WORD_W-BYTE_W){1'b0}}, scalar_inverse};
            end
            OP_REGION_MUL, OP_REGION_XOR:
            begin
                result_bytes = region_result;
            end
            default:
            begin
                result_bytes = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/core/gf256_multiply_accumulate_unit_core.sv -----
// Top level of the GF(2^8) multiply-accumulate unit: input register, datapath, result register.
//
// The unit takes one beat per clock cycle while the response side does not stall, and returns one
// result beat for each, in order. A beat is captured in the input register, passes the GF(2^8)
// logic (eight lane multipliers and a scalar multiplier fed by an inverse table)
// combinationally, and is then registered in the result register, from which the response
// side reads it. Both registers move together as a two-stage pipeline: request ready stays
// high whenever the result register is empty or is being drained, and a stalled response
// holds at most two beats in flight. Polynomial is 0x11d; scalar results sit in the low byte.
`default_nettype none

module gf256_multiply_accumulate_unit_core
    import gfmac_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    gfmac_in_if.sink      request,
    gfmac_out_if.source   response
);

    logic              stage_valid_reg;
    logic              stage_valid_next;
    item_t             stage_item_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [WORD_W-1:0] out_data_reg;
    logic [WORD_W-1:0] result_bytes;
    logic              advance;
    logic              accept;

    // The result register can take a new value when it is empty or being read this cycle.
    assign advance = !out_valid_reg || response.ready;
    assign request.ready = !stage_valid_reg || advance;
    assign accept = request.valid && request.ready;

    gfmac_datapath u_datapath (
        .item         (stage_item_reg),
        .result_bytes (result_bytes)
    );

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        out_valid_next   = out_valid_reg;
        if (advance)
        begin
            out_valid_next   = stage_valid_reg;
            stage_valid_next = accept;
        end
        else if (accept)
        begin
            stage_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_item_reg.operation         <= request.operation;
            stage_item_reg.data_bytes        <= request.data_bytes;
            stage_item_reg.multiplier        <= request.multiplier;
            stage_item_reg.accumulator_bytes <= request.accumulator_bytes;
            stage_item_reg.byte_count        <= request.byte_count;
        end
        if (advance && stage_valid_reg)
        begin
            out_data_reg <= result_bytes;
        end
    end

    assign response.valid        = out_valid_reg;
    assign response.result_bytes = out_data_reg;

endmodule

`default_nettype wire

// ----- rtl/core/gfmac_checker.sv -----
// Port-level checker for the multiply-accumulate unit, bound to the top level.
`default_nettype none

module gfmac_checker
    import gfmac_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic [WORD_W-1:0] result_bytes
);

    logic in_fire;

    assign in_fire = in_valid && in_ready;

    // A stalled result beat stays and keeps its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_bytes))
        else $error("result beat changed while stalled");

    // With no result pending the unit must be able to take a request.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("request stalled while the result register is empty");

    // An accepted beat moves into the result register at the next edge when the output is
    // not blocked there.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire ##1 (!out_valid || out_ready) |=> out_valid)
        else $error("accepted beat did not reach the output");

    // A result that appears on an empty output was accepted and passed through the input register before it appeared.
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_fire, 2))
        else $error("result appeared without an accepted request");

endmodule

bind gf256_multiply_accumulate_unit_core gfmac_checker u_gfmac_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (request.valid),
    .in_ready     (request.ready),
    .out_valid    (response.valid),
    .out_ready    (response.ready),
    .result_bytes (response.result_bytes)
);

`default_nettype wire

// ----- sim/testbench.sv -----
// Self-checking testbench for the GF(2^8) multiply-accumulate unit with random flow control.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import gfmac_pkg::*;

    localparam int RANDOM_ITEMS = 1950;
    localparam int IDLE_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = 8;

    // Operation codes the unit does not define; they must return an all-zero word.
    localparam logic [OP_W-1:0] OP_RESERVED_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_RESERVED_HI = 3'd7;

    localparam logic [8:0] FIELD_POLY = 9'h11d;

    localparam int STALL_NONE     = 0;
    localparam int STALL_RANDOM   = 1;
    localparam int STALL_PERIODIC = 2;
    localparam int STALL_STREAK   = 3;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    gfmac_in_if  req_bus ();
    gfmac_out_if rsp_bus ();

    gf256_multiply_accumulate_unit_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (req_bus),
        .response (rsp_bus)
    );

    item_t             pending_requests [$];
    logic [WORD_W-1:0] expected_results [$];
    logic [BYTE_W-1:0] inverse_lut [256];

    item_t             accepted_beat;
    logic [WORD_W-1:0] wanted_word;
    int                error_count   = 0;
    int                idle_cycles   = 0;
    bit                beat_accepted = 1'b0;
    bit                progress      = 1'b0;
    int                burst_left    = 1;
    int                gap_left      = 0;
    int                stall_mode    = STALL_NONE;
    int                window_left   = 0;
    int                stall_left    = 0;
    int                period_phase  = 0;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Carry-less product, then fold the high bits back with the field polynomial.
    function automatic logic [BYTE_W-1:0] field_mul(input logic [BYTE_W-1:0] a,
                                                    input logic [BYTE_W-1:0] b);
        logic [14:0] prod;
        prod = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
            begin
                prod = prod ^ (15'(a) << i);
            end
        end
        for (int i = 14; i >= 8; i--)
        begin
            if (prod[i])
            begin
                prod = prod ^ (15'(FIELD_POLY) << (i - 8));
            end
        end
        return prod[7:0];
    endfunction

    function automatic logic [WORD_W-1:0] predict_result(input item_t it);
        logic [WORD_W-1:0] word;
        logic [BYTE_W-1:0] lo;
        logic [BYTE_W-1:0] lane_val;
        int                lanes;
        lo   = it.data_bytes[BYTE_W-1:0];
        word = '0;
        case (it.operation)
            OP_MUL:
            begin
                word[BYTE_W-1:0] = field_mul(lo, it.multiplier);
            end
            OP_DIV:
            begin
                word[BYTE_W-1:0] = field_mul(lo, inverse_lut[it.multiplier]);
            end
            OP_INV:
            begin
                word[BYTE_W-1:0] = inverse_lut[lo];
            end
            OP_REGION_MUL, OP_REGION_XOR:
            begin
                lanes = (int'(it.byte_count) > LANE_LIMIT) ? LANE_LIMIT : int'(it.byte_count);
                word  = it.accumulator_bytes;
                for (int k = 0; k < lanes; k++)
                begin
                    lane_val = field_mul(it.data_bytes[8*k +: 8], it.multiplier);
                    if (it.operation == OP_REGION_XOR)
                    begin
                        lane_val = lane_val ^ it.accumulator_bytes[8*k +: 8];
                    end
                    word[8*k +: 8] = lane_val;
                end
            end
            default:
            begin
                word = '0;
            end
        endcase
        return word;
    endfunction

    task automatic add_item(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] data,
                            input logic [BYTE_W-1:0] mult, input logic [WORD_W-1:0] acc,
                            input logic [COUNT_W-1:0] count);
        item_t it;
        it.operation         = op;
        it.data_bytes        = data;
        it.multiplier        = mult;
        it.accumulator_bytes = acc;
        it.byte_count        = count;
        pending_requests.push_back(it);
    endtask

    task automatic add_random_item();
        int                pick;
        logic [OP_W-1:0]   op;
        logic [WORD_W-1:0] data;
        logic [BYTE_W-1:0] mult;
        logic [COUNT_W-1:0] count;
        pick = $urandom_range(0, 99);
        if (pick < 15)
            op = OP_MUL;
        else if (pick < 27)
            op = OP_DIV;
        else if (pick < 37)
            op = OP_INV;
        else if (pick < 65)
            op = OP_REGION_MUL;
        else if (pick < 95)
            op = OP_REGION_XOR;
        else
            op = OP_W'($urandom_range(OP_RESERVED_LO, OP_RESERVED_HI));

        case ($urandom_range(0, 15))
            0:       data = '0;
            1:       data = '1;
            default: data = {$urandom, $urandom};
        endcase

        case ($urandom_range(0, 15))
            0:       mult = 8'h00;
            1:       mult = 8'h01;
            2:       mult = 8'hff;
            default: mult = BYTE_W'($urandom);
        endcase

        // Mostly legal lane counts, with zero and the saturating values mixed in.
        if ($urandom_range(0, 99) < 88)
            count = COUNT_W'($urandom_range(1, 8));
        else
            count = COUNT_W'($urandom_range(0, 15));

        add_item(op, data, mult, {$urandom, $urandom}, count);
    endtask

    // Request driver: bursts of beats separated by random gaps; a beat is held until taken.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            req_bus.valid <= 1'b0;
        end
        else if (!(req_bus.valid && !beat_accepted))
        begin
            if (gap_left > 0)
            begin
                req_bus.valid <= 1'b0;
                gap_left--;
            end
            else if (pending_requests.size() > 0)
            begin
                req_bus.valid             <= 1'b1;
                req_bus.operation         <= pending_requests[0].operation;
                req_bus.data_bytes        <= pending_requests[0].data_bytes;
                req_bus.multiplier        <= pending_requests[0].multiplier;
                req_bus.accumulator_bytes <= pending_requests[0].accumulator_bytes;
                req_bus.byte_count        <= pending_requests[0].byte_count;
                if (burst_left > 1)
                begin
                    burst_left--;
                end
                else
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 10);
                end
            end
            else
            begin
                req_bus.valid <= 1'b0;
            end
        end
        beat_accepted = 1'b0;
    end

    // Response backpressure: the stall pattern switches between a few modes over time.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            rsp_bus.ready <= 1'b0;
        end
        else
        begin
            if (window_left == 0)
            begin
                stall_mode  = $urandom_range(STALL_NONE, STALL_STREAK);
                window_left = $urandom_range(16, 160);
            end
            else
            begin
                window_left--;
            end
            case (stall_mode)
                STALL_NONE:
                begin
                    rsp_bus.ready <= 1'b1;
                end
                STALL_RANDOM:
                begin
                    rsp_bus.ready <= ($urandom_range(0, 99) >= 40);
                end
                STALL_PERIODIC:
                begin
                    period_phase = (period_phase + 1) % 5;
                    rsp_bus.ready <= (period_phase >= 2);
                end
                default:
                begin
                    if (stall_left > 0)
                    begin
                        rsp_bus.ready <= 1'b0;
                        stall_left--;
                    end
                    else if ($urandom_range(0, 7) == 0)
                    begin
                        rsp_bus.ready <= 1'b0;
                        stall_left = $urandom_range(1, 24);
                    end
                    else
                    begin
                        rsp_bus.ready <= 1'b1;
                    end
                end
            endcase
        end
    end

    // Monitor: predicts each accepted request beat and checks each response beat in order.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            progress = 1'b0;
            if (req_bus.valid && req_bus.ready)
            begin
                accepted_beat = {req_bus.operation, req_bus.data_bytes, req_bus.multiplier,
                                 req_bus.accumulator_bytes, req_bus.byte_count};
                expected_results.push_back(predict_result(accepted_beat));
                void'(pending_requests.pop_front());
                beat_accepted = 1'b1;
                progress      = 1'b1;
            end
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                progress = 1'b1;
                if (expected_results.size() == 0)
                begin
                    $error("result_bytes: expected no beat, actual %h", rsp_bus.result_bytes);
                    error_count++;
                end
                else
                begin
                    wanted_word = expected_results.pop_front();
                    if (rsp_bus.result_bytes !== wanted_word)
                    begin
                        $error("result_bytes: expected %h, actual %h",
                               wanted_word, rsp_bus.result_bytes);
                        error_count++;
                    end
                end
            end
            if (progress || (pending_requests.size() == 0 && expected_results.size() == 0))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial
    begin
        req_bus.valid             = 1'b0;
        req_bus.operation         = '0;
        req_bus.data_bytes        = '0;
        req_bus.multiplier        = '0;
        req_bus.accumulator_bytes = '0;
        req_bus.byte_count        = '0;
        rsp_bus.ready             = 1'b0;

        // Inverses by exhaustive search; zero maps to zero.
        inverse_lut[0] = 8'h00;
        for (int x = 1; x < 256; x++)
        begin
            for (int y = 1; y < 256; y++)
            begin
                if (field_mul(BYTE_W'(x), BYTE_W'(y)) == 8'h01)
                begin
                    inverse_lut[x] = BYTE_W'(y);
                end
            end
        end

        // Scalar operations, with junk in the upper data bytes that must be ignored.
        add_item(OP_MUL, 64'hffff_ffff_ffff_ff00, 8'hff, 64'h0123_4567_89ab_cdef, 4'd8);
        add_item(OP_MUL, 64'h0000_0000_0000_00ff, 8'hff, 64'h0, 4'd1);
        add_item(OP_MUL, 64'h5a5a_5a5a_5a5a_5a80, 8'h02, 64'hffff_ffff_ffff_ffff, 4'd15);
        add_item(OP_MUL, 64'h0000_0000_0000_0001, 8'ha5, 64'h0, 4'd0);
        add_item(OP_DIV, 64'hdead_beef_0000_0037, 8'h00, 64'h0, 4'd8);
        add_item(OP_DIV, 64'h0000_0000_0000_00ff, 8'hff, 64'h0, 4'd8);
        add_item(OP_DIV, 64'h8000_0000_0000_0053, 8'hca, 64'h0, 4'd8);
        add_item(OP_INV, 64'hffff_ffff_ffff_ff00, 8'h00, 64'h0, 4'd8);
        add_item(OP_INV, 64'h0000_0000_0000_0001, 8'h77, 64'h0, 4'd8);
        add_item(OP_INV, 64'h0000_0000_0000_00ff, 8'hff, 64'h0, 4'd8);
        // Region operations across lane counts, including zero and counts past the word.
        add_item(OP_REGION_MUL, 64'hffff_ffff_ffff_ffff, 8'hff, 64'h0, 4'd8);
        add_item(OP_REGION_MUL, 64'h0102_0408_1020_4080, 8'h1d, 64'h1111_2222_3333_4444, 4'd1);
        add_item(OP_REGION_MUL, 64'hffff_ffff_ffff_ffff, 8'h35, 64'hfedc_ba98_7654_3210, 4'd0);
        add_item(OP_REGION_MUL, 64'h0f1e_2d3c_4b5a_6978, 8'h80, 64'h0, 4'd15);
        add_item(OP_REGION_MUL, 64'hffff_ffff_ffff_ffff, 8'h00, 64'hffff_ffff_ffff_ffff, 4'd5);
        add_item(OP_REGION_XOR, 64'hffff_ffff_ffff_ffff, 8'hff, 64'hffff_ffff_ffff_ffff, 4'd8);
        add_item(OP_REGION_XOR, 64'h8080_8080_8080_8080, 8'h02, 64'h0000_0000_0000_0000, 4'd3);
        add_item(OP_REGION_XOR, 64'h1234_5678_9abc_def0, 8'h01, 64'h0fed_cba9_8765_4321, 4'd0);
        add_item(OP_REGION_XOR, 64'h1234_5678_9abc_def0, 8'hc3, 64'h0fed_cba9_8765_4321, 4'd9);
        add_item(OP_REGION_XOR, 64'h0000_0000_0000_0000, 8'h00, 64'haaaa_5555_aaaa_5555, 4'd7);
        // Undefined operation codes return zero regardless of the operands.
        add_item(OP_RESERVED_LO, 64'hffff_ffff_ffff_ffff, 8'hff, 64'hffff_ffff_ffff_ffff, 4'd8);
        add_item(OP_RESERVED_HI, 64'h1234_5678_9abc_def0, 8'h5c, 64'h0fed_cba9_8765_4321, 4'd4);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            add_random_item();
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_requests.size() != 0 || expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
